// File: rtl/core/gcm_pkg.sv
// gcm_pkg: shared types and constants of the greedy change maker
// no dependencies
package gcm_pkg;

  localparam int unsigned DenW = 16;
  localparam int unsigned IdxW = 3;
  localparam int unsigned NumDenomRegs = 6;

  // register indexes on the config port
  localparam logic [2:0] REG_DENOM_COUNT = 3'd0;
  localparam logic [2:0] REG_DENOM_0     = 3'd1;
  localparam logic [2:0] REG_DENOM_5     = 3'd6;

  localparam logic [2:0] COUNT_RESET = 3'd6;

  function automatic logic [DenW-1:0] denom_reset(input logic [2:0] k);
    logic [DenW-1:0] v;
    case (k)
      3'd0:    v = 16'd500;
      3'd1:    v = 16'd200;
      3'd2:    v = 16'd100;
      3'd3:    v = 16'd50;
      3'd4:    v = 16'd20;
      3'd5:    v = 16'd10;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FINISH
  } gcm_state_e;

  // one table position as it moves along the cell row
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [DenW-1:0] val;
  } gcm_entry_t;

endpackage

// File: rtl/core/greedy_change_maker_core.sv
// greedy_change_maker_core: top level of the greedy change maker
// depends on gcm_pkg, gcm_cell, gcm_div
//
// pulse start with an amount while busy is low; the block walks the table one
// position per cycle, stalling while a division runs, in a row of cells (each
// cell hands its entry to its left neighbor, the head cell is the position under
// test), and for every position that fits it runs a bit-serial division over
// the working width (AMOUNT_WIDTH, capped at 16 bits). records come out one per
// beat on rec_valid_o for exactly one cycle each; the receiver cannot stall,
// so it must take every beat. the final beat carries last_o.
module greedy_change_maker_core
  import gcm_pkg::*;
#(
  parameter int unsigned MAX_DENOMS   = 6,
  parameter int unsigned AMOUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [15:0] change_amount_i,
  // result side
  output logic        rec_valid_o,
  output logic [2:0]  denom_index_o,
  output logic [15:0] denom_value_o,
  output logic [15:0] note_count_o,
  output logic [15:0] remaining_o,
  output logic        shortfall_o,
  output logic        last_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // working width of the amount and number of cells in the row
  localparam int unsigned RemW = (AMOUNT_WIDTH < DenW) ? AMOUNT_WIDTH : DenW;
  localparam int unsigned NumCells =
      (MAX_DENOMS < NumDenomRegs) ? MAX_DENOMS : NumDenomRegs;

  // ---------------- config registers ----------------
  logic [2:0]      count_q;
  logic [DenW-1:0] denom_q [NumDenomRegs];
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      for (int k = 0; k < NumDenomRegs; k++) begin
        denom_q[k] <= denom_reset(3'(k));
      end
    end else if (wr_en) begin
      if (reg_idx == REG_DENOM_COUNT) begin
        count_q <= pwdata[2:0];
      end
      for (int k = 0; k < NumDenomRegs; k++) begin
        if (reg_idx == REG_DENOM_0 + 3'(k)) begin
          denom_q[k] <= pwdata[DenW-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DENOM_COUNT) begin
      prdata = {29'd0, count_q};
    end else if (reg_idx <= REG_DENOM_5) begin
      prdata = {16'd0, denom_q[reg_idx - REG_DENOM_0]};
    end
  end

  // ---------------- control ----------------
  gcm_state_e      state_q, state_d;
  logic            accept;
  logic [RemW-1:0] rem_q, rem_d, amount_q, amount_d;
  logic [2:0]      left_q, left_d;
  logic [2:0]      used;
  logic            load_row, shift_row, div_start;
  logic            div_done;
  logic [RemW-1:0] div_quot, div_rem;
  gcm_entry_t      head;
  logic            head_fits;

  // pending record, held until we know whether it is the last one
  logic            pend_v_q, pend_v_d;
  gcm_entry_t      pend_ent_q, pend_ent_d;
  logic [RemW-1:0] pend_cnt_q, pend_cnt_d, pend_rem_q, pend_rem_d;

  // output beat registers
  logic            out_v_q, out_v_d;
  logic [2:0]      out_idx_q, out_idx_d;
  logic [15:0]     out_val_q, out_val_d, out_cnt_q, out_cnt_d, out_rem_q, out_rem_d;
  logic            out_sf_q, out_sf_d, out_last_q, out_last_d;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign used   = (count_q > 3'(NumCells)) ? 3'(NumCells) : count_q;
  assign head_fits = (head.val != '0) && ({{(32-RemW){1'b0}}, rem_q} >= 32'(head.val));

  // ---------------- row of cells ----------------
  gcm_entry_t row [NumCells+1];
  assign row[NumCells] = '0;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    gcm_entry_t ld;
    assign ld.idx = IdxW'(g);
    assign ld.val = denom_q[g];
    gcm_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (load_row),
      .shift_i      (shift_row),
      .load_entry_i (ld),
      .next_entry_i (row[g+1]),
      .entry_o      (row[g])
    );
  end
  assign head = row[0];

  gcm_div #(.RemW(RemW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (head.val),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (rem_q == '0 || left_q == '0) begin
          state_d = ST_FINISH;
        end else if (head_fits) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_SCAN;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    load_row   = 1'b0;
    shift_row  = 1'b0;
    div_start  = 1'b0;
    rem_d      = rem_q;
    amount_d   = amount_q;
    left_d     = left_q;
    pend_v_d   = pend_v_q;
    pend_ent_d = pend_ent_q;
    pend_cnt_d = pend_cnt_q;
    pend_rem_d = pend_rem_q;
    out_v_d    = 1'b0;
    out_idx_d  = pend_ent_q.idx;
    out_val_d  = pend_ent_q.val;
    out_cnt_d  = 16'(pend_cnt_q);
    out_rem_d  = 16'(pend_rem_q);
    out_sf_d   = 1'b0;
    out_last_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load_row = 1'b1;
          rem_d    = change_amount_i[RemW-1:0];
          amount_d = change_amount_i[RemW-1:0];
          left_d   = used;
          pend_v_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rem_q != '0 && left_q != '0) begin
          if (head_fits) begin
            div_start = 1'b1;
          end else begin
            shift_row = 1'b1;
            left_d    = left_q - 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // a new fit means the held record is not the last
          out_v_d    = pend_v_q;
          pend_v_d   = 1'b1;
          pend_ent_d = head;
          pend_cnt_d = div_quot;
          pend_rem_d = div_rem;
          rem_d      = div_rem;
          shift_row  = 1'b1;
          left_d     = left_q - 1'b1;
        end
      end
      ST_FINISH: begin
        out_v_d    = 1'b1;
        out_last_d = 1'b1;
        if (pend_v_q) begin
          out_sf_d = (rem_q != '0);
        end else begin
          // empty record: nothing was paid
          out_idx_d = '0;
          out_val_d = '0;
          out_cnt_d = '0;
          out_rem_d = 16'(amount_q);
          out_sf_d  = (amount_q != '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      left_q   <= '0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    amount_q   <= amount_d;
    pend_ent_q <= pend_ent_d;
    pend_cnt_q <= pend_cnt_d;
    pend_rem_q <= pend_rem_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_cnt_q  <= out_cnt_d;
    out_rem_q  <= out_rem_d;
    out_sf_q   <= out_sf_d;
    out_last_q <= out_last_d;
  end

  assign rec_valid_o   = out_v_q;
  assign denom_index_o = out_idx_q;
  assign denom_value_o = out_val_q;
  assign note_count_o  = out_cnt_q;
  assign remaining_o   = out_rem_q;
  assign shortfall_o   = out_sf_q;
  assign last_o        = out_last_q;

`ifndef SYNTH
  // a beat that is not the last is always followed by more work
  a_more_after_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && !last_o |-> busy)
    else $error("non-last beat while idle");

  // shortfall is only flagged on the final beat
  a_sf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && shortfall_o |-> last_o)
    else $error("shortfall on non-last beat");

  // the divider only finishes while a division is awaited
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider done outside division");
`endif

endmodule

// File: rtl/core/gcm_cell.sv
// gcm_cell: one cell of the denomination row, holds one table entry
// depends on gcm_pkg
module gcm_cell
  import gcm_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       shift_i,
  input  gcm_entry_t load_entry_i,
  input  gcm_entry_t next_entry_i,
  output gcm_entry_t entry_o
);

  gcm_entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = load_entry_i;
    end else if (shift_i) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/core/gcm_div.sv
// gcm_div: restoring divider, one quotient bit per cycle
// depends on gcm_pkg
module gcm_div
  import gcm_pkg::*;
#(
  parameter int unsigned RemW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RemW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [RemW-1:0] quot_o,
  output logic [RemW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(RemW + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   part_q, part_d;
  logic [RemW-1:0] dq_q, dq_d;
  logic [DenW-1:0] dsr_q, dsr_d;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {part_q[DenW-1:0], dq_q[RemW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    part_d = part_q;
    dq_d   = dq_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(RemW);
      part_d = '0;
      dq_d   = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      part_d = ge ? (trial - {1'b0, dsr_q}) : trial;
      dq_d   = {dq_q[RemW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    dq_q   <= dq_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = part_q[RemW-1:0];

endmodule

// File: dv/tb.sv
// tb: self-checking bench for greedy_change_maker_core
// depends on gcm_pkg and the core rtl; drives amounts, programs the table over apb,
// predicts change records and compares every record beat
module tb;
  import gcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] val;
    logic [15:0] cnt;
    logic [15:0] rem;
    logic        sf;
    logic        lst;
  } change_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] change_amount_i;
  logic        rec_valid_o;
  logic [2:0]  denom_index_o;
  logic [15:0] denom_value_o;
  logic [15:0] note_count_o;
  logic [15:0] remaining_o;
  logic        shortfall_o;
  logic        last_o;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  greedy_change_maker_core u_top (
    .clk_i, .rst_ni, .start, .busy, .change_amount_i,
    .rec_valid_o, .denom_index_o, .denom_value_o, .note_count_o,
    .remaining_o, .shortfall_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor copy of the register file
  logic [2:0]  model_count;
  logic [15:0] model_denoms [NumDenomRegs];

  logic [15:0]  amount_q [$];   // amounts waiting for the driver
  change_rec_t  change_q [$];   // records expected from the block
  int           errors;
  int           idle_cycles;
  int           gap_left;
  logic         cfg_busy;       // config task owns the apb pins

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // greedy walk over the table, same order as the block
  task automatic predict_change(input logic [15:0] amount);
    logic [16:0] rem;
    int          used;
    int          i;
    int          n;
    change_rec_t r;
    rem  = {1'b0, amount};
    used = (model_count > 6) ? 6 : model_count;
    i    = 0;
    n    = 0;
    while (rem != 0 && i < used) begin
      while (i < used && (model_denoms[i] == 0 || rem < model_denoms[i])) i++;
      if (i < used) begin
        r.idx = i[2:0];
        r.val = model_denoms[i];
        r.cnt = 16'(rem / model_denoms[i]);
        rem   = rem % model_denoms[i];
        r.rem = rem[15:0];
        r.sf  = 1'b0;
        r.lst = 1'b0;
        change_q.push_back(r);
        n++;
        i++;
      end
    end
    if (n == 0) begin
      r = '{idx: 3'd0, val: 16'd0, cnt: 16'd0, rem: amount,
            sf: (amount != 0), lst: 1'b1};
      change_q.push_back(r);
    end else begin
      r = change_q.pop_back();
      r.sf  = (rem != 0);
      r.lst = 1'b1;
      change_q.push_back(r);
    end
  endtask

  // driver: one amount per command beat, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start           <= 1'b0;
      change_amount_i <= '0;
      gap_left        <= 0;
    end else if (start && !busy) begin
      // beat taken at this edge; predict from the amount that was on the pins
      predict_change(change_amount_i);
      void'(amount_q.pop_front());
      start    <= 1'b0;
      gap_left <= $urandom_range(0, 14);
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (amount_q.size() > 0 && !cfg_busy) begin
        start           <= 1'b1;
        change_amount_i <= amount_q[0];
      end
    end
  end

  // monitor: every record beat must match the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rec_valid_o) begin
      change_rec_t got;
      change_rec_t exp;
      got = '{idx: denom_index_o, val: denom_value_o, cnt: note_count_o,
              rem: remaining_o, sf: shortfall_o, lst: last_o};
      if (change_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected record %p", got);
      end else begin
        exp = change_q.pop_front();
        if (got !== exp) begin
          errors++;
          if (errors <= 10) $display("record mismatch exp %p got %p", exp, got);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || rec_valid_o || cfg_busy || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("FAIL");
      $finish;
    end
  end

  // apb write: setup then access phase, pready is tied high
  task automatic reg_write(input int index, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * index);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == REG_DENOM_COUNT) model_count = value[2:0];
    else model_denoms[index - 1] = value[15:0];
  endtask

  // wait until the block has drained, so the table can be reprogrammed
  task automatic drain();
    while (amount_q.size() > 0 || change_q.size() > 0 || start || busy)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_table(input logic [2:0] cnt, input logic [15:0] d0,
                            d1, d2, d3, d4, d5);
    cfg_busy = 1'b1;
    reg_write(REG_DENOM_COUNT, {29'd0, cnt});
    reg_write(1, {16'd0, d0});
    reg_write(2, {16'd0, d1});
    reg_write(3, {16'd0, d2});
    reg_write(4, {16'd0, d3});
    reg_write(5, {16'd0, d4});
    reg_write(REG_DENOM_5, {16'd0, d5});
    cfg_busy = 1'b0;
  endtask

  // mostly small amounts that walk the table, some full-range ones
  function automatic logic [15:0] rand_amount();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 50));
      default: return 16'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [15:0] rand_denom();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'd0;
      default: return 16'($urandom_range(1, 600));
    endcase
  endfunction

  initial begin
    errors   = 0;
    cfg_busy = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    model_count = COUNT_RESET;
    for (int k = 0; k < NumDenomRegs; k++) model_denoms[k] = denom_reset(3'(k));
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed on reset table: zero, extremes, exact fits, shortfall
    amount_q = {16'd0, 16'd65535, 16'd5, 16'd10, 16'd880, 16'd500, 16'd999,
                16'd1, 16'd45, 16'hAAAA, 16'h5555};
    drain();

    // zero entries, non-descending table, count clamped above six
    load_table(3'd7, 16'd0, 16'd3, 16'd65535, 16'd7, 16'd0, 16'd1);
    amount_q = {16'd65535, 16'd2, 16'd100, 16'd0, 16'd6};
    drain();
    // no entries in use
    load_table(3'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    amount_q = {16'd0, 16'd7, 16'd65535};
    drain();
    // largest single denomination
    load_table(3'd1, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    amount_q = {16'd65535, 16'd65534};
    drain();

    // random phases, each with its own table
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) load_table(3'd6, 16'd500, 16'd200, 16'd100, 16'd50, 16'd20, 16'd10);
      else load_table(3'($urandom_range(0, 7)), rand_denom(), rand_denom(),
                      rand_denom(), rand_denom(), rand_denom(), rand_denom());
      for (int n = 0; n < 48; n++) amount_q.push_back(rand_amount());
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/gcm_pkg.sv
rtl/core/gcm_cell.sv
rtl/core/gcm_div.sv
rtl/core/greedy_change_maker_core.sv
dv/tb.sv
